### hw/rtl/asc_pkg.sv
`timescale 1ns / 1ps

package asc_pkg;

  // Filter and threshold averaging rings (powers of two, divide by shift)
  localparam int FILT_TAPS  = 4;
  localparam int FILT_SHIFT = $clog2(FILT_TAPS);
  localparam int FILT_PW    = $clog2(FILT_TAPS);
  localparam int THR_TAPS   = 4;
  localparam int THR_SHIFT  = $clog2(THR_TAPS);
  localparam int THR_PW     = $clog2(THR_TAPS);

  localparam int WIN_LEN_DEF = 17;

  localparam logic [14:0] MID_RESET     = 15'd4000;
  localparam logic [16:0] MID_SUM_RESET = 17'(4000 * THR_TAPS);
  localparam logic [14:0] SENS_RESET    = 15'd1700;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd50;
  localparam logic [2:0]  CONFIRM_RESET = 3'd4;
  localparam logic [23:0] TOTAL_MAX     = 24'hFFFFFF;

  typedef logic [14:0] mag_t;

  typedef enum logic [1:0] {
    REG_SENSITIVITY      = 2'd0,
    REG_VALLEY_TIMEOUT   = 2'd1,
    REG_STEPS_TO_CONFIRM = 2'd2
  } reg_index_t;

  // Result of one window pass
  typedef struct packed {
    mag_t centre;
    logic is_max;
    logic is_min;
    logic ready;
  } win_res_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_CRD,
    W_CGET,
    W_SCAN,
    W_DONE
  } win_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_FILT,
    T_WAIT,
    T_DECIDE,
    T_VAL1,
    T_VAL2,
    T_VAL3,
    T_OUT
  } top_state_t;

endpackage

### hw/rtl/asc_window.sv
`timescale 1ns / 1ps

module asc_window #(
  parameter int WIN_LEN = asc_pkg::WIN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  asc_pkg::mag_t    avg,
  output logic             done,
  output asc_pkg::win_res_t res
);
  import asc_pkg::*;

  localparam int AW     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int FW     = $clog2(WIN_LEN + 1);
  localparam int CENTRE = WIN_LEN / 2;

  mag_t           mem [WIN_LEN];
  mag_t           rdata;
  win_state_t     state;
  win_state_t     state_next;
  logic [AW-1:0]  wp;        // oldest entry once the new sample is in
  logic [AW-1:0]  idx;       // window index whose data is on rdata
  logic [AW-1:0]  caddr;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  rd_off;
  logic [AW:0]    rd_sum;
  logic [FW-1:0]  fill;
  logic           ready;
  logic           mem_we;
  mag_t           centre;
  logic           is_max;
  logic           is_min;

  assign mem_we = (state == W_IDLE) && start;
  assign done   = (state == W_DONE);
  assign res    = '{centre: centre, is_max: is_max, is_min: is_min, ready: ready};

  always_comb begin
    unique case (state)
      W_CRD:   rd_off = AW'(CENTRE);
      W_SCAN:  rd_off = idx + AW'(1);
      default: rd_off = '0;
    endcase
    rd_sum  = {1'b0, wp} + {1'b0, rd_off};
    rd_addr = (rd_sum >= (AW+1)'(WIN_LEN)) ? AW'(rd_sum - (AW+1)'(WIN_LEN)) : rd_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= avg;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      W_IDLE: if (start) state_next = W_CRD;
      W_CRD:  state_next = W_CGET;
      W_CGET: state_next = ready ? W_SCAN : W_DONE;
      W_SCAN: if (idx == AW'(WIN_LEN - 1)) state_next = W_DONE;
      W_DONE: state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      fill  <= '0;
      ready <= 1'b0;
    end else if (mem_we) begin
      // entries at or above the fill count are never written yet: a centre read there gives zero
      ready <= (fill == FW'(WIN_LEN));
      if (fill != FW'(WIN_LEN)) begin
        fill <= fill + FW'(1);
      end
      wp <= (wp == AW'(WIN_LEN - 1)) ? '0 : wp + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      W_CRD: begin
        caddr <= rd_addr;
      end
      W_CGET: begin
        centre <= (ready || ({1'b0, caddr} < (AW+1)'(fill))) ? rdata : '0;
        is_max <= 1'b1;
        is_min <= 1'b1;
        idx    <= '0;
      end
      W_SCAN: begin
        if (idx != AW'(CENTRE)) begin
          if (rdata >= centre) is_max <= 1'b0;
          if (rdata <= centre) is_min <= 1'b0;
        end
        idx <= idx + AW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/accel_step_counter.sv
`timescale 1ns / 1ps

// Path: each input beat is registered as a magnitude, then filtered and written into
//   the window, whose memory scan reads one entry a cycle (skipped while the window
//   fills); a found valley is scored in T_VAL1..T_VAL3 before the output register loads.
// Throughput: one sample at a time; the next beat is taken once the result is
//   registered, while that result may still wait on the output side.
// Reset (rst, synchronous): filter, window fill, threshold ring, run and count
//   return to their start values; registers to 1700 / 50 / 4.
module accel_step_counter #(
  parameter int WINDOW_LENGTH = asc_pkg::WIN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x[13:0], accel_y[27:14], accel_z[41:28], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // total_steps[23:0], steps_added[26:24],
                                 // center_value[41:27], window_ready[42], zero pad
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import asc_pkg::*;

  top_state_t  state;
  top_state_t  state_next;

  logic [14:0] sensitivity;
  logic [7:0]  valley_timeout;
  logic [2:0]  steps_to_confirm;

  mag_t               mag;
  mag_t               raw_ring [FILT_TAPS];
  logic [16:0]        raw_sum;
  logic [16:0]        raw_sum_next;
  logic [FILT_PW-1:0] raw_pos;
  mag_t               avg;

  mag_t              mid_ring [THR_TAPS];
  logic [16:0]       mid_sum;
  logic [16:0]       mid_sum_next;
  logic [THR_PW-1:0] mid_pos;
  mag_t              mid;
  mag_t              threshold_now;

  logic        seeking_valley;
  logic [7:0]  since_peak;
  logic [8:0]  since_inc;
  mag_t        peak_value;
  logic        miss_flag;
  logic [2:0]  run_length;
  logic [23:0] step_total;
  logic [2:0]  added;
  logic [2:0]  credit_n;
  logic [24:0] credit_sum;
  logic        hit;

  logic        win_start;
  logic        win_done;
  win_res_t    win_res;
  win_res_t    res;

  logic        out_load;
  logic [23:0] out_total;
  logic [2:0]  out_added;
  mag_t        out_centre;
  logic        out_ready;

  logic [13:0] ax, ay, az;

  asc_window #(
    .WIN_LEN(WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .start (win_start),
    .avg   (avg),
    .done  (win_done),
    .res   (win_res)
  );

  // Manhattan magnitude; the most negative code gives 8192
  assign ax = s_tdata[13]  ? 14'(~s_tdata[13:0]  + 14'd1) : s_tdata[13:0];
  assign ay = s_tdata[27]  ? 14'(~s_tdata[27:14] + 14'd1) : s_tdata[27:14];
  assign az = s_tdata[41]  ? 14'(~s_tdata[41:28] + 14'd1) : s_tdata[41:28];

  assign raw_sum_next = raw_sum - {2'b0, raw_ring[raw_pos]} + {2'b0, mag};
  assign avg          = 15'(raw_sum_next >> FILT_SHIFT);

  assign mid          = 15'(({1'b0, peak_value} + {1'b0, res.centre}) >> 1);
  assign mid_sum_next = mid_sum - {2'b0, mid_ring[mid_pos]} + {2'b0, mid};
  assign since_inc    = {1'b0, since_peak} + 9'd1;

  assign m_tdata = {5'b0, out_ready, out_centre, out_added, out_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity      <= SENS_RESET;
      valley_timeout   <= TIMEOUT_RESET;
      steps_to_confirm <= CONFIRM_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_SENSITIVITY:      sensitivity      <= cfg_data;
        REG_VALLEY_TIMEOUT:   valley_timeout   <= cfg_data[7:0];
        REG_STEPS_TO_CONFIRM: steps_to_confirm <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    win_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = T_FILT;
      end
      T_FILT: begin
        win_start  = 1'b1;
        state_next = T_WAIT;
      end
      T_WAIT: if (win_done) state_next = T_DECIDE;
      T_DECIDE: begin
        if (res.ready && seeking_valley && res.is_min) state_next = T_VAL1;
        else state_next = T_OUT;
      end
      T_VAL1: state_next = T_VAL2;
      T_VAL2: state_next = T_VAL3;
      T_VAL3: state_next = T_OUT;
      T_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // credit amount for a confirmed step
  always_comb begin
    if (run_length < steps_to_confirm) begin
      credit_n = (run_length + 3'd1 == steps_to_confirm) ? steps_to_confirm : 3'd0;
    end else begin
      credit_n = 3'd1;
    end
    credit_sum = {1'b0, step_total} + {22'b0, credit_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_sum <= '0;
      raw_pos <= '0;
      for (int i = 0; i < FILT_TAPS; i++) raw_ring[i] <= '0;
      mid_sum       <= MID_SUM_RESET;
      mid_pos       <= '0;
      threshold_now <= MID_RESET;
      for (int i = 0; i < THR_TAPS; i++) mid_ring[i] <= MID_RESET;
      seeking_valley <= 1'b0;
      since_peak     <= '0;
      peak_value     <= '0;
      miss_flag      <= 1'b0;
      run_length     <= '0;
      step_total     <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (s_tvalid) mag <= 15'({1'b0, ax} + {1'b0, ay} + {1'b0, az});
        end
        T_FILT: begin
          raw_sum           <= raw_sum_next;
          raw_ring[raw_pos] <= mag;
          raw_pos           <= raw_pos + FILT_PW'(1);
        end
        T_WAIT: begin
          res   <= win_res;
          added <= '0;
        end
        T_DECIDE: begin
          if (res.ready) begin
            if (!seeking_valley) begin
              if (res.is_max) begin
                peak_value     <= res.centre;
                seeking_valley <= 1'b1;
                since_peak     <= '0;
              end
            end else begin
              since_peak <= since_inc[8] ? 8'hFF : since_inc[7:0];
              if (!res.is_min && (since_inc > {1'b0, valley_timeout})) begin
                run_length     <= '0;
                seeking_valley <= 1'b0;
              end
            end
          end
        end
        T_VAL1: begin
          // signed drop peak - valley > sensitivity, all operands non-negative
          if ({2'b0, peak_value} > {2'b0, res.centre} + {2'b0, sensitivity}) begin
            mid_ring[mid_pos] <= mid;
            mid_sum           <= mid_sum_next;
            threshold_now     <= 15'(mid_sum_next >> THR_SHIFT);
            mid_pos           <= mid_pos + THR_PW'(1);
          end
        end
        T_VAL2: begin
          // valley < th - half rewritten as valley + half < th
          hit <= ({1'b0, peak_value} > {1'b0, threshold_now} + {2'b0, sensitivity[14:1]})
              && ({1'b0, res.centre} + {2'b0, sensitivity[14:1]} < {1'b0, threshold_now});
        end
        T_VAL3: begin
          seeking_valley <= 1'b0;
          if (hit) begin
            miss_flag <= 1'b0;
            if (run_length < steps_to_confirm) run_length <= run_length + 3'd1;
            added      <= credit_n;
            step_total <= (credit_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : credit_sum[23:0];
          end else if (miss_flag) begin
            miss_flag  <= 1'b0;
            run_length <= '0;
          end else begin
            miss_flag <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total  <= step_total;
      out_added  <= added;
      out_centre <= res.centre;
      out_ready  <= res.ready;
    end
  end

endmodule

### bench/accel_step_counter_tb.sv
`timescale 1ns / 1ps

module accel_step_counter_tb;
  import asc_pkg::*;

  localparam int WIN         = WIN_LEN_DEF;
  localparam int CENTRE      = WIN / 2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;
  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind this index

  typedef struct packed {
    logic [13:0] z;
    logic [13:0] y;
    logic [13:0] x;
  } sample_t;

  typedef struct packed {
    logic        ready;
    logic [14:0] centre;
    logic [2:0]  added;
    logic [23:0] total;
  } count_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  sample_t     samples_pending[$];
  count_beat_t counts_due[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 75;
  int beats_in = 0;
  int beats_out = 0;
  int err_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // step detector shadow state
  int flt_ring[FILT_TAPS];
  int flt_sum, flt_at;
  int win_buf[WIN];
  int win_fill;
  bit in_valley_hunt;
  int peak_age, peak_mag;
  int mid_hist[THR_TAPS];
  int mid_total, mid_at, thresh;
  bit missed;
  int streak, credited_total;
  int sens, vtimeout, confirm;

  accel_step_counter DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  task automatic reset_detector();
    for (int i = 0; i < FILT_TAPS; i++) flt_ring[i] = 0;
    for (int i = 0; i < WIN; i++) win_buf[i] = 0;
    for (int i = 0; i < THR_TAPS; i++) mid_hist[i] = int'(MID_RESET);
    flt_sum = 0;
    flt_at = 0;
    win_fill = 0;
    in_valley_hunt = 1'b0;
    peak_age = 0;
    peak_mag = 0;
    mid_total = int'(MID_SUM_RESET);
    mid_at = 0;
    thresh = int'(MID_RESET);
    missed = 1'b0;
    streak = 0;
    credited_total = 0;
    sens = int'(SENS_RESET);
    vtimeout = int'(TIMEOUT_RESET);
    confirm = int'(CONFIRM_RESET);
  endtask

  function automatic int abs_axis(logic [13:0] v);
    logic signed [13:0] s;
    s = v;
    return (s < 0) ? -int'(s) : int'(s);
  endfunction

  function automatic int add_steps(int n);
    credited_total = (credited_total + n > int'(TOTAL_MAX)) ? int'(TOTAL_MAX)
                                                            : credited_total + n;
    return n;
  endfunction

  // One sample through filter, window and peak/valley tracker
  function automatic count_beat_t predict_count(sample_t smp);
    int mag, avg, centre, added, pk, vl, half, age, mid;
    bit top, bottom, ready;
    count_beat_t r;
    mag = abs_axis(smp.x) + abs_axis(smp.y) + abs_axis(smp.z);
    added = 0;
    ready = 1'b0;
    flt_sum = flt_sum - flt_ring[flt_at] + mag;
    avg = flt_sum / FILT_TAPS;
    flt_ring[flt_at] = mag;
    flt_at = (flt_at + 1) % FILT_TAPS;
    for (int i = 0; i < WIN - 1; i++) win_buf[i] = win_buf[i + 1];
    win_buf[WIN - 1] = avg;
    centre = win_buf[CENTRE];
    if (win_fill >= WIN) begin
      ready = 1'b1;
      top = 1'b1;
      bottom = 1'b1;
      for (int i = 0; i < WIN; i++) begin
        if (i != CENTRE) begin
          if (win_buf[i] >= centre) top = 1'b0;
          if (win_buf[i] <= centre) bottom = 1'b0;
        end
      end
      if (!in_valley_hunt) begin
        if (top) begin
          peak_mag = centre;
          in_valley_hunt = 1'b1;
          peak_age = 0;
        end
      end else begin
        age = peak_age + 1;
        peak_age = (age > 255) ? 255 : age;
        if (bottom) begin
          pk = peak_mag;
          vl = centre;
          half = sens >> 1;
          // signed drop: a valley above its peak never moves the threshold
          if (pk - vl > sens) begin
            mid = (pk + vl) >> 1;
            mid_total = mid_total - mid_hist[mid_at] + mid;
            thresh = mid_total / THR_TAPS;
            mid_hist[mid_at] = mid;
            mid_at = (mid_at + 1) % THR_TAPS;
          end
          if (pk > thresh + half && vl < thresh - half) begin
            missed = 1'b0;
            if (streak < confirm) begin
              streak++;
              if (streak == confirm) added = add_steps(confirm);
            end else begin
              added = add_steps(1);
            end
          end else if (missed) begin
            missed = 1'b0;
            streak = 0;
          end else begin
            missed = 1'b1;
          end
          in_valley_hunt = 1'b0;
        end else if (age > vtimeout) begin
          streak = 0;
          in_valley_hunt = 1'b0;
        end
      end
    end else begin
      win_fill++;
    end
    r.total = credited_total[23:0];
    r.added = added[2:0];
    r.centre = centre[14:0];
    r.ready = ready;
    return r;
  endfunction

  task automatic push_sample(int x, int y, int z);
    sample_t s;
    s.x = x[13:0];
    s.y = y[13:0];
    s.z = z[13:0];
    samples_pending.push_back(s);
  endtask

  // spread a magnitude over three axes with random signs
  task automatic push_mag(int m);
    int ax, ay, az, rest;
    ax = $urandom_range((m > 16382) ? m - 16382 : 0, (m < 8191) ? m : 8191);
    rest = m - ax;
    ay = $urandom_range((rest > 8191) ? rest - 8191 : 0, (rest < 8191) ? rest : 8191);
    az = rest - ay;
    push_sample($urandom_range(0, 1) ? -ax : ax, $urandom_range(0, 1) ? -ay : ay,
                $urandom_range(0, 1) ? -az : az);
  endtask

  // mostly walking gait, with flat stretches and noise bursts between
  task automatic make_activity(int n);
    int made, kind, len, m, p, amp, base;
    real ph;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) push_sample($urandom_range(0, 16383), $urandom_range(0, 16383),
                                 $urandom_range(0, 16383));
        made += len;
      end else if (kind == 1) begin
        len = $urandom_range(30, 90);
        m = $urandom_range(0, 24573);
        repeat (len) push_mag(m);
        made += len;
      end else begin
        len = $urandom_range(40, 140);
        p = $urandom_range(18, 44);
        amp = $urandom_range(200, 9000);
        base = $urandom_range(amp, amp + 6000);
        ph = $urandom_range(0, 999) / 1000.0;
        for (int k = 0; k < len; k++) begin
          if (k % p == 0 && $urandom_range(0, 3) == 0) base = $urandom_range(amp, amp + 6000);
          m = base + $rtoi(amp * $sin(6.2831853 * (k + ph) / p)) + $urandom_range(0, 20);
          push_mag(m);
        end
        made += len;
      end
    end
    // cut the last burst short so exactly n samples are added
    while (made > n) begin
      void'(samples_pending.pop_back());
      made--;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[14:0];
    case (idx)
      REG_SENSITIVITY:      sens = val & 32'h7FFF;
      REG_VALLEY_TIMEOUT:   vtimeout = val & 32'hFF;
      REG_STEPS_TO_CONFIRM: confirm = val & 32'h7;
      default: ;
    endcase
  endtask

  task automatic set_regs(int s, int t, int c);
    write_reg(REG_SENSITIVITY, s);
    write_reg(REG_VALLEY_TIMEOUT, t);
    write_reg(REG_STEPS_TO_CONFIRM, c);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sampled mid-cycle so the sender's and receiver's updates are settled
  task automatic drain();
    do @(negedge clk);
    while (samples_pending.size() != 0 || s_tvalid || counts_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", beats_out, what, got, want);
    err_count++;
  endtask

  task automatic check_count(logic [47:0] d);
    count_beat_t want;
    beats_out++;
    if (counts_due.size() == 0) begin
      report_mismatch("unexpected beat, total_steps", int'(d[23:0]), 0);
    end else begin
      want = counts_due.pop_front();
      if (d[23:0] !== want.total)
        report_mismatch("total_steps", int'(d[23:0]), int'(want.total));
      if (d[26:24] !== want.added)
        report_mismatch("steps_added", int'(d[26:24]), int'(want.added));
      if (d[41:27] !== want.centre)
        report_mismatch("center_value", int'(d[41:27]), int'(want.centre));
      if (d[42] !== want.ready)
        report_mismatch("window_ready", int'(d[42]), int'(want.ready));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        counts_due.push_back(predict_count(sample_t'(s_tdata[41:0])));
        beats_in <= beats_in + 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {6'b0, samples_pending.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_count(m_tdata);
      m_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // one long back-pressure stretch early on, sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && beats_in >= 40) begin
      stall_left <= 400;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("accel_step_counter test failed");
      $finish;
    end
  end

  initial begin
    reset_detector();
    // axis extremes, sign edges and alternating bit patterns
    push_sample(0, 0, 0);
    push_sample(8191, 8191, 8191);
    push_sample(-8192, -8192, -8192);
    push_sample(-1, -1, -1);
    push_sample(1, -1, 0);
    push_sample(8191, -8192, 0);
    push_sample(-8192, 0, 8191);
    push_sample(0, 8191, -8192);
    push_sample(14'h1555, 14'h2AAA, 14'h1555);
    push_sample(14'h2AAA, 14'h1555, 14'h2AAA);
    push_sample(-8191, 8191, -8191);
    push_sample(8192 - 1, -1, 1);
    push_sample(-8192, -8192, 8191);
    push_sample(0, 0, 0);
    push_sample(4096, -4096, 2048);
    push_sample(-2, 2, -8192);
    push_sample(8191, 0, 0);
    push_sample(0, 0, 0);
    push_sample(-8192, -8192, -8192);
    push_sample(100, 200, -300);
    make_activity(200);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    drain();

    set_regs(0, 255, 1);
    write_reg(REG_SPARE, 15'h7FFF);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    make_activity(210);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 29;
    set_regs(32767, 15'h7E01, 7);
    make_activity(210);
    drain();

    set_regs(24576, 200, 0);
    make_activity(210);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(900, 30, 3);
    make_activity(220);
    drain();

    set_regs(2600, 80, 7);
    make_activity(220);
    drain();

    if (err_count == 0) begin
      $display("accel_step_counter test passed");
    end else begin
      $display("accel_step_counter test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/asc_pkg.sv
hw/rtl/asc_window.sv
hw/rtl/accel_step_counter.sv
bench/accel_step_counter_tb.sv
